>>> rtl/rakt_pkg.sv
// Shared types and constants for the reference-count aging key table.
// Holds the transfer payload structs, status codes, cell command struct and defaults.
// No dependencies.
package rakt_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W      = 32;
  localparam int FIELD_W    = 7;   // occupancy, removed and watermark width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 2'd1;

  localparam logic [FIELD_W-1:0] HIGH_MARK_RST = 7'd64;
  localparam logic [FIELD_W-1:0] LOW_MARK_RST  = 7'd32;

  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_CLEAN = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_LOW      = 3'd3,
    ST_CLEANED  = 3'd4
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             check_low_mark;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] occupancy;
    logic [FIELD_W-1:0] removed;
  } out_item_t;

  // Broadcast command to every cell in the row
  typedef struct packed {
    logic look;   // register key match
    logic inc;    // bump count of the matching cell
    logic ins;    // write key into the selected cell
    logic dec;    // age all valid counts, flag the freed ones
    logic shift;  // pass removal flags one cell down the row
  } cell_cmd_t;

endpackage

>>> rtl/rakt_cell.sv
// One table entry: valid bit, key and saturating reference count.
// Flags freed entries and shifts the flags down the row for counting.
// Depends on rakt_pkg.
module rakt_cell #(
  parameter int COUNT_BITS = rakt_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rakt_pkg::cell_cmd_t        cmd,
  input  logic                       sel,
  input  logic [rakt_pkg::KEY_W-1:0] key_in,
  input  logic                       flag_in,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic                       flag_o
);
  import rakt_pkg::*;

  logic                  valid_r;
  logic                  match_r;
  logic                  flag_r;
  logic [KEY_W-1:0]      key_r;
  logic [COUNT_BITS-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      if (cmd.look) begin
        match_r <= valid_r && (key_r == key_in);
      end
      if (cmd.inc && match_r && (count_r != '1)) begin
        count_r <= count_r + COUNT_BITS'(1);
      end
      if (cmd.ins && sel) begin
        valid_r <= 1'b1;
        key_r   <= key_in;
        count_r <= COUNT_BITS'(1);
      end
      if (cmd.dec) begin
        // free on reaching zero, else age by one
        flag_r <= valid_r && (count_r <= COUNT_BITS'(1));
        if (valid_r) begin
          if (count_r <= COUNT_BITS'(1)) begin
            valid_r <= 1'b0;
          end else begin
            count_r <= count_r - COUNT_BITS'(1);
          end
        end
      end else if (cmd.shift) begin
        flag_r <= flag_in;
      end
    end
  end

  assign valid_o = valid_r;
  assign hit_o   = match_r;
  assign flag_o  = flag_r;

endmodule

>>> rtl/refcount_aging_key_table_core.sv
// Top level of the reference-count aging key table: control sequencer and cell row.
// Depends on rakt_pkg and rakt_cell.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one item per transfer:
//   a reference of a key or a clean pass. Every item gives exactly one result
//   on the output channel (out_valid/out_ready/out_data): hit, inserted,
//   refused full, clean refused low, or clean done with the removed count.
//   Watermarks are set through cfg_we/cfg_index/cfg_wdata; the user must do so
//   only while idle, as the block does not enforce it; index 0 is high_mark,
//   index 1 is low_mark, other indexes are ignored.
// Sequencing: one item is in flight at a time. A reference or a refused clean
//   passes through the look and apply states before its result is registered,
//   and the next item is taken once that result is delivered. A clean that runs
//   ages the row in parallel, then the freed-entry flags shift out of the row one
//   cell per cycle and are counted at its end, so the row length sets its duration.
// Reset: all entries invalid, occupancy zero, high_mark 64, low_mark 32.
// Stall: a finished result waits in the output register; if the register is
//   still occupied the result is held internally until the receiver drains it.
module refcount_aging_key_table_core #(
  parameter int ENTRIES    = rakt_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = rakt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rakt_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rakt_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rakt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rakt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rakt_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SWP_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_COUNT,
    S_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [SWP_W-1:0]   swp_r, swp_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic [FIELD_W-1:0] hm_r, hm_nxt;
  logic [FIELD_W-1:0] lm_r, lm_nxt;

  cell_cmd_t          cmd;
  logic [ENTRIES-1:0] sel_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] flag_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] free_onehot;

  logic               any_hit;
  logic               ref_block;
  logic               low_block;
  logic [CNT_W-1:0]   rem_sum;
  logic [CNT_W-1:0]   total_inc;
  logic               fin;
  out_item_t          res_c;

  // Row of entry cells; removal flags move toward the last cell
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic flag_src;
    if (i == 0) begin : g_head
      assign flag_src = 1'b0;
    end else begin : g_body
      assign flag_src = flag_vec[i-1];
    end
    rakt_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .sel     (sel_vec[i]),
      .key_in  (item_r.key),
      .flag_in (flag_src),
      .valid_o (valid_vec[i]),
      .hit_o   (hit_vec[i]),
      .flag_o  (flag_vec[i])
    );
  end

  // Lowest free slot as a one-hot mask
  assign free_vec    = ~valid_vec;
  assign free_onehot = free_vec & (~free_vec + ENTRIES'(1));
  assign any_hit     = |hit_vec;
  assign ref_block   = 32'(total_r) >= 32'(hm_r);
  assign low_block   = 32'(total_r) <= 32'(lm_r);
  assign rem_sum     = rem_r + CNT_W'(flag_vec[ENTRIES-1]);
  assign total_inc   = total_r + CNT_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    swp_nxt       = swp_r;
    res_nxt       = res_r;
    hm_nxt        = hm_r;
    lm_nxt        = lm_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    sel_vec       = '0;
    fin           = 1'b0;
    res_c         = res_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_MARK: hm_nxt = cfg_wdata;
        REG_LOW_MARK:  lm_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (item_r.kind == KIND_REF) begin
          fin   = 1'b1;
          res_c = '{status: ST_FULL, occupancy: FIELD_W'(total_r), removed: '0};
          if (!ref_block) begin
            if (any_hit) begin
              cmd.inc      = 1'b1;
              res_c.status = ST_HIT;
            end else if (free_vec != '0) begin
              cmd.ins         = 1'b1;
              sel_vec         = free_onehot;
              total_nxt       = total_inc;
              res_c.status    = ST_INSERTED;
              res_c.occupancy = FIELD_W'(total_inc);
            end
          end
        end else if (item_r.check_low_mark && low_block) begin
          fin   = 1'b1;
          res_c = '{status: ST_LOW, occupancy: FIELD_W'(total_r), removed: '0};
        end else begin
          cmd.dec   = 1'b1;
          rem_nxt   = '0;
          swp_nxt   = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        // Count one flag from the row end, advance the row
        cmd.shift = 1'b1;
        rem_nxt   = rem_sum;
        if (swp_r == SWP_W'(ENTRIES - 1)) begin
          fin       = 1'b1;
          total_nxt = total_r - rem_sum;
          res_c     = '{status: ST_CLEANED, occupancy: FIELD_W'(total_r - rem_sum),
                        removed: FIELD_W'(rem_sum)};
        end else begin
          swp_nxt = swp_r + SWP_W'(1);
        end
      end
      S_HOLD: begin
        fin   = 1'b1;
        res_c = res_r;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Deliver the result, or hold it while the output register is occupied
    if (fin) begin
      if (!out_valid_r || out_ready) begin
        out_data_nxt  = res_c;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = res_c;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      hm_r        <= HIGH_MARK_RST;
      lm_r        <= LOW_MARK_RST;
      rem_r       <= '0;
      swp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      hm_r        <= hm_nxt;
      lm_r        <= lm_nxt;
      rem_r       <= rem_nxt;
      swp_r       <= swp_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/rakt_checker.sv
// Port-level checks for refcount_aging_key_table_core, bound to the top level.
// Depends on rakt_pkg and the top level's port list.
module rakt_checker #(
  parameter int ENTRIES = rakt_pkg::ENTRIES_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rakt_pkg::out_item_t out_data
);
  import rakt_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Only a completed clean reports removed entries
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_CLEANED) |-> out_data.removed == '0)
    else $error("removed nonzero on a non-clean result");

  // Occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ENTRIES > 127) || (32'(out_data.occupancy) <= ENTRIES))
    else $error("occupancy above table size");

endmodule

bind refcount_aging_key_table_core rakt_checker #(.ENTRIES(ENTRIES)) u_rakt_checker (.*);
